// File: rtl/spline_kernel_unit_interval_assert.svh
// Assertion macros shared by the spline kernel RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SPLINE_KERNEL_UNIT_INTERVAL_ASSERT_SVH
`define SPLINE_KERNEL_UNIT_INTERVAL_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SKUI_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A trigger that demands a condition in the same cycle.
`define SKUI_CHECK_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// A trigger that demands a condition in the next cycle.
`define SKUI_CHECK_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: rtl/skui_pkg.sv
// Package for the spline kernel block: word type, fixed point constants,
// divisor codes, lane control structs and latencies. Depends on nothing.
package skui_pkg;

    localparam int WORK_FRAC        = 60;
    localparam int IN_FRAC_DEFAULT  = 16;
    localparam int OUT_FRAC_DEFAULT = 44;
    localparam int KERNEL_W         = 48;
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;

    localparam int SMUL_LAT  = 5;
    localparam int RDIV_LAT  = 6;
    localparam int POINT_LAT = 2 * SMUL_LAT + RDIV_LAT;
    localparam int DIFF_LAT  = 4 * SMUL_LAT + RDIV_LAT;
    localparam int ALIGN_LAT = DIFF_LAT - POINT_LAT;

    typedef logic signed [63:0] skui_word_t;

    localparam skui_word_t Q_ONE  = skui_word_t'(64'd1 << WORK_FRAC);
    localparam skui_word_t Q_HALF = skui_word_t'(64'd1 << (WORK_FRAC - 1));

    // p/q with 60 fraction bits, rounded to nearest with ties up.
    localparam logic [127:0] QS2 = 128'd1 << (WORK_FRAC + 1);
    localparam skui_word_t Q_1_12     = skui_word_t'(((QS2 * 128'd1) / 128'd12 + 128'd1) >> 1);
    localparam skui_word_t Q_1_4      = skui_word_t'(((QS2 * 128'd1) / 128'd4 + 128'd1) >> 1);
    localparam skui_word_t Q_1_2      = skui_word_t'(((QS2 * 128'd1) / 128'd2 + 128'd1) >> 1);
    localparam skui_word_t Q_7_240    = skui_word_t'(((QS2 * 128'd7) / 128'd240 + 128'd1) >> 1);
    localparam skui_word_t Q_5_4      = skui_word_t'(((QS2 * 128'd5) / 128'd4 + 128'd1) >> 1);
    localparam skui_word_t Q_7_16     = skui_word_t'(((QS2 * 128'd7) / 128'd16 + 128'd1) >> 1);
    localparam skui_word_t Q_31_1344  =
        skui_word_t'(((QS2 * 128'd31) / 128'd1344 + 128'd1) >> 1);
    localparam skui_word_t Q_7_3      = skui_word_t'(((QS2 * 128'd7) / 128'd3 + 128'd1) >> 1);
    localparam skui_word_t Q_49_24    = skui_word_t'(((QS2 * 128'd49) / 128'd24 + 128'd1) >> 1);
    localparam skui_word_t Q_31_48    = skui_word_t'(((QS2 * 128'd31) / 128'd48 + 128'd1) >> 1);
    localparam skui_word_t Q_127_3840 =
        skui_word_t'(((QS2 * 128'd127) / 128'd3840 + 128'd1) >> 1);

    // Reciprocals floor((2^64 - 1) / den) for the rounding divider.
    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] RCP_1     = ALL_ONES / 64'd1;
    localparam logic [63:0] RCP_2     = ALL_ONES / 64'd2;
    localparam logic [63:0] RCP_6     = ALL_ONES / 64'd6;
    localparam logic [63:0] RCP_24    = ALL_ONES / 64'd24;
    localparam logic [63:0] RCP_720   = ALL_ONES / 64'd720;
    localparam logic [63:0] RCP_40320 = ALL_ONES / 64'd40320;

    typedef enum logic [2:0] {
        DIV_1,
        DIV_2,
        DIV_6,
        DIV_24,
        DIV_720,
        DIV_40320
    } skui_div_t;

    typedef enum logic [2:0] {
        KIND_LINEAR   = 3'd0,
        KIND_CUBIC    = 3'd1,
        KIND_QUINTIC  = 3'd2,
        KIND_SEPTIC   = 3'd3,
        KIND_PERIODIC = 3'd4
    } skui_kind_t;

    localparam logic [2:0] KIND_RESET = KIND_CUBIC;
    localparam logic       REG_KIND   = 1'b0;

    typedef enum logic [1:0] {
        ASEL_ONE,
        ASEL_D,
        ASEL_U
    } skui_asel_t;

    // Point lane: k = (a_op * (b_is_d ? d : u + b_add) + p_add) / div.
    typedef struct packed {
        skui_asel_t asel;
        logic       b_is_d;
        skui_word_t b_add;
        skui_word_t p_add;
        skui_div_t  div;
    } skui_point_ctrl_t;

    // Difference lane: Horner steps over u, a step without u multiplies by one.
    typedef struct packed {
        skui_word_t c0;
        logic [2:0] use_u;
        skui_word_t c1;
        skui_word_t c2;
        skui_word_t c3;
        skui_div_t  div;
    } skui_diff_ctrl_t;

    function automatic logic [15:0] div_den(skui_div_t code);
        logic [15:0] den;
        unique case (code)
            DIV_1:     den = 16'd1;
            DIV_2:     den = 16'd2;
            DIV_6:     den = 16'd6;
            DIV_24:    den = 16'd24;
            DIV_720:   den = 16'd720;
            DIV_40320: den = 16'd40320;
            default:   den = 16'd1;
        endcase
        return den;
    endfunction

    function automatic logic [63:0] div_rcp(skui_div_t code);
        logic [63:0] rcp;
        unique case (code)
            DIV_1:     rcp = RCP_1;
            DIV_2:     rcp = RCP_2;
            DIV_6:     rcp = RCP_6;
            DIV_24:    rcp = RCP_24;
            DIV_720:   rcp = RCP_720;
            DIV_40320: rcp = RCP_40320;
            default:   rcp = RCP_1;
        endcase
        return rcp;
    endfunction

endpackage

// File: rtl/skui_smul.sv
// Five stage signed fixed point multiplier, (a + a_add) * b with 60 fraction
// bits, rounded half away from zero. Depends on skui_pkg.
module skui_smul (
    input  logic                 clk,
    input  logic                 en,
    input  skui_pkg::skui_word_t a,
    input  skui_pkg::skui_word_t a_add,
    input  skui_pkg::skui_word_t b,
    output skui_pkg::skui_word_t p
);
    import skui_pkg::*;

    skui_word_t  s_reg;
    skui_word_t  b_reg;
    logic [63:0] xm_reg;
    logic [63:0] ym_reg;
    logic        neg2_reg;
    logic [63:0] p00_reg;
    logic [63:0] p01_reg;
    logic [63:0] p10_reg;
    logic [63:0] p11_reg;
    logic        neg3_reg;
    logic [64:0] hi_reg;
    logic        neg4_reg;
    skui_word_t  p_reg;

    logic [63:0]  xm_next;
    logic [63:0]  ym_next;
    logic [127:0] sum_next;
    logic [63:0]  r_next;
    skui_word_t   p_next;

    always_comb
    begin
        xm_next  = s_reg[63] ? (64'd0 - $unsigned(s_reg)) : $unsigned(s_reg);
        ym_next  = b_reg[63] ? (64'd0 - $unsigned(b_reg)) : $unsigned(b_reg);
        sum_next = {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                 + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
        r_next   = hi_reg[64:1] + {63'd0, hi_reg[0]};
        p_next   = neg4_reg ? $signed(64'd0 - r_next) : $signed(r_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= a + a_add;
            b_reg    <= b;
            xm_reg   <= xm_next;
            ym_reg   <= ym_next;
            neg2_reg <= s_reg[63] ^ b_reg[63];
            p00_reg  <= 64'(xm_reg[31:0]) * 64'(ym_reg[31:0]);
            p01_reg  <= 64'(xm_reg[31:0]) * 64'(ym_reg[63:32]);
            p10_reg  <= 64'(xm_reg[63:32]) * 64'(ym_reg[31:0]);
            p11_reg  <= 64'(xm_reg[63:32]) * 64'(ym_reg[63:32]);
            neg3_reg <= neg2_reg;
            hi_reg   <= sum_next[WORK_FRAC + 63:WORK_FRAC - 1];
            neg4_reg <= neg3_reg;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/skui_rdiv.sv
// Six stage rounding divider, (a + a_add) / den to nearest with ties away
// from zero, by reciprocal multiply and one correction. Depends on skui_pkg.
module skui_rdiv (
    input  logic                 clk,
    input  logic                 en,
    input  skui_pkg::skui_word_t a,
    input  skui_pkg::skui_word_t a_add,
    input  skui_pkg::skui_div_t  div,
    output skui_pkg::skui_word_t q
);
    import skui_pkg::*;

    skui_word_t  s_reg;
    skui_div_t   div1_reg;
    logic [63:0] n2_reg;
    logic        neg2_reg;
    skui_div_t   div2_reg;
    logic [63:0] p00_reg;
    logic [63:0] p01_reg;
    logic [63:0] p10_reg;
    logic [63:0] p11_reg;
    logic [63:0] n3_reg;
    logic        neg3_reg;
    skui_div_t   div3_reg;
    logic [63:0] qe4_reg;
    logic [63:0] n4_reg;
    logic        neg4_reg;
    skui_div_t   div4_reg;
    logic [63:0] qd5_reg;
    logic [63:0] qe5_reg;
    logic [63:0] n5_reg;
    logic        neg5_reg;
    skui_div_t   div5_reg;
    skui_word_t  q_reg;

    logic [63:0]  mag_next;
    logic [15:0]  den1_next;
    logic [63:0]  n2_next;
    logic [63:0]  rcp_next;
    logic [127:0] sum_next;
    logic [63:0]  rem_next;
    logic [63:0]  den5_next;
    logic [63:0]  qf_next;
    skui_word_t   q_next;

    always_comb
    begin
        mag_next  = s_reg[63] ? (64'd0 - $unsigned(s_reg)) : $unsigned(s_reg);
        den1_next = div_den(div1_reg);
        n2_next   = mag_next + {49'd0, den1_next[15:1]};
        rcp_next  = div_rcp(div2_reg);
        sum_next  = {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                  + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
        den5_next = {48'd0, div_den(div5_reg)};
        rem_next  = n5_reg - qd5_reg;
        qf_next   = qe5_reg + {63'd0, (rem_next >= den5_next)};
        q_next    = neg5_reg ? $signed(64'd0 - qf_next) : $signed(qf_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= a + a_add;
            div1_reg <= div;
            n2_reg   <= n2_next;
            neg2_reg <= s_reg[63];
            div2_reg <= div1_reg;
            p00_reg  <= 64'(n2_reg[31:0]) * 64'(rcp_next[31:0]);
            p01_reg  <= 64'(n2_reg[31:0]) * 64'(rcp_next[63:32]);
            p10_reg  <= 64'(n2_reg[63:32]) * 64'(rcp_next[31:0]);
            p11_reg  <= 64'(n2_reg[63:32]) * 64'(rcp_next[63:32]);
            n3_reg   <= n2_reg;
            neg3_reg <= neg2_reg;
            div3_reg <= div2_reg;
            qe4_reg  <= sum_next[127:64];
            n4_reg   <= n3_reg;
            neg4_reg <= neg3_reg;
            div4_reg <= div3_reg;
            qd5_reg  <= qe4_reg * {48'd0, div_den(div4_reg)};
            qe5_reg  <= qe4_reg;
            n5_reg   <= n4_reg;
            neg5_reg <= neg4_reg;
            div5_reg <= div4_reg;
            q_reg    <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: rtl/skui_point_lane.sv
// Point lane: one of k1..k4 of a centred point, chosen by the control struct.
// Depends on skui_pkg, skui_smul and skui_rdiv.
module skui_point_lane (
    input  logic                       clk,
    input  logic                       en,
    input  skui_pkg::skui_word_t       d,
    input  skui_pkg::skui_point_ctrl_t ctrl,
    output skui_pkg::skui_word_t       k
);
    import skui_pkg::*;

    skui_word_t d_dly_reg [SMUL_LAT];
    skui_word_t u;
    skui_word_t a2;
    skui_word_t a2_add;
    skui_word_t b2;
    skui_word_t prod;

    skui_smul u_sq (
        .clk   (clk),
        .en    (en),
        .a     (d),
        .a_add ('0),
        .b     (d),
        .p     (u)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_dly_reg[0] <= d;
            for (int i = 1; i < SMUL_LAT; i++)
            begin
                d_dly_reg[i] <= d_dly_reg[i - 1];
            end
        end
    end

    always_comb
    begin
        a2     = ctrl.b_is_d ? d_dly_reg[SMUL_LAT - 1] : u;
        a2_add = ctrl.b_is_d ? skui_word_t'(0) : ctrl.b_add;
        case (ctrl.asel)
            ASEL_D:  b2 = d_dly_reg[SMUL_LAT - 1];
            ASEL_U:  b2 = u;
            default: b2 = Q_ONE;
        endcase
    end

    skui_smul u_poly (
        .clk   (clk),
        .en    (en),
        .a     (a2),
        .a_add (a2_add),
        .b     (b2),
        .p     (prod)
    );

    skui_rdiv u_div (
        .clk   (clk),
        .en    (en),
        .a     (prod),
        .a_add (ctrl.p_add),
        .div   (ctrl.div),
        .q     (k)
    );

endmodule

// File: rtl/skui_diff_lane.sv
// Difference lane: k2, k4, k6 or k8 of the centred distance by three Horner
// steps over u. Depends on skui_pkg, skui_smul and skui_rdiv.
module skui_diff_lane (
    input  logic                      clk,
    input  logic                      en,
    input  skui_pkg::skui_word_t      d,
    input  skui_pkg::skui_diff_ctrl_t ctrl,
    output skui_pkg::skui_word_t      k
);
    import skui_pkg::*;

    skui_word_t u_dly_reg [2 * SMUL_LAT];
    skui_word_t u;
    skui_word_t h1;
    skui_word_t h2;
    skui_word_t h3;
    skui_word_t m1;
    skui_word_t m2;
    skui_word_t m3;

    skui_smul u_sq (
        .clk   (clk),
        .en    (en),
        .a     (d),
        .a_add ('0),
        .b     (d),
        .p     (u)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_dly_reg[0] <= u;
            for (int i = 1; i < 2 * SMUL_LAT; i++)
            begin
                u_dly_reg[i] <= u_dly_reg[i - 1];
            end
        end
    end

    assign m1 = ctrl.use_u[0] ? u : Q_ONE;
    assign m2 = ctrl.use_u[1] ? u_dly_reg[SMUL_LAT - 1] : Q_ONE;
    assign m3 = ctrl.use_u[2] ? u_dly_reg[2 * SMUL_LAT - 1] : Q_ONE;

    skui_smul u_step1 (
        .clk   (clk),
        .en    (en),
        .a     (u),
        .a_add (ctrl.c0),
        .b     (m1),
        .p     (h1)
    );

    skui_smul u_step2 (
        .clk   (clk),
        .en    (en),
        .a     (h1),
        .a_add (ctrl.c1),
        .b     (m2),
        .p     (h2)
    );

    skui_smul u_step3 (
        .clk   (clk),
        .en    (en),
        .a     (h2),
        .a_add (ctrl.c2),
        .b     (m3),
        .p     (h3)
    );

    skui_rdiv u_div (
        .clk   (clk),
        .en    (en),
        .a     (h3),
        .a_add (ctrl.c3),
        .div   (ctrl.div),
        .q     (k)
    );

endmodule

// File: rtl/spline_kernel_unit_interval.sv
// Top level of the unit interval spline kernel: front stage, lanes, combine,
// output rounding and a two word output buffer. Depends on skui_pkg and all
// skui_* modules, and on the assertion macro header.
//
// Usage: each word on the pair channel (pair_valid, pair_stall) carries two
// points x_point, y_point in [0,1] and a last_pair flag. Each accepted word
// yields exactly one word on the result channel (result_valid, result_stall):
// the kernel value in signed Q3.44, saturated, and last_out, a copy of the
// flag. Words leave in the order in which they arrived.
// Throughput is one word per cycle unless the pipeline holds. The depth is set
// by the front stage, the difference lane (four five stage multipliers and a six
// stage divider), then the product of the two point lanes and two output stages.
// Kinds 5 to 7 give zero.
// The kernel kind sits in an APB register at address 0 (reset: cubic) and must
// be written only while no words are in flight; the block does not enforce this.
// Reset restores the kind and clears the pipeline valid bits and output buffer.
// When the receiver stalls, the two word output buffer keeps taking results;
// only once it is full and still stalled does the whole pipeline hold and
// pair_stall rise. Nothing is lost or repeated.
`include "spline_kernel_unit_interval_assert.svh"

module spline_kernel_unit_interval #(
    parameter int IN_FRAC_BITS  = skui_pkg::IN_FRAC_DEFAULT,
    parameter int OUT_FRAC_BITS = skui_pkg::OUT_FRAC_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [skui_pkg::ADDR_W - 1:0]      paddr,
    input  logic [skui_pkg::DATA_W - 1:0]      pwdata,
    output logic [skui_pkg::DATA_W - 1:0]      prdata,
    output logic                               pready,
    input  logic                               pair_valid,
    output logic                               pair_stall,
    input  logic [IN_FRAC_BITS:0]              x_point,
    input  logic [IN_FRAC_BITS:0]              y_point,
    input  logic                               last_pair,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [skui_pkg::KERNEL_W - 1:0] kernel_value,
    output logic                               last_out
);
    import skui_pkg::*;

    localparam int PIPE_LAT   = 1 + DIFF_LAT + SMUL_LAT + 2;
    localparam int CSH        = WORK_FRAC - IN_FRAC_BITS;
    localparam int SH         = WORK_FRAC - OUT_FRAC_BITS;
    localparam int MAG_W      = 65 - SH;
    localparam int FIFO_DEPTH = 2;
    localparam logic [1:0] FIFO_FULL = 2'(FIFO_DEPTH);
    localparam logic [IN_FRAC_BITS:0] PT_ONE = {1'b1, {IN_FRAC_BITS{1'b0}}};
    localparam logic [64:0] RND_HALF = 65'd1 << (SH - 1);
    localparam logic [63:0] LIM_POS  = (64'd1 << (KERNEL_W - 1)) - 64'd1;
    localparam logic [63:0] LIM_NEG  = 64'd1 << (KERNEL_W - 1);

    typedef struct packed {
        logic signed [KERNEL_W - 1:0] value;
        logic                         last;
    } skui_result_t;

    // Configuration.
    logic [2:0] kind_reg;
    logic       cfg_write;

    // Pipeline control.
    logic       vld_reg  [PIPE_LAT];
    logic       last_reg [PIPE_LAT];
    logic       pipe_en;
    logic       push;
    logic       pop;

    // Front stage.
    logic [IN_FRAC_BITS:0] xc;
    logic [IN_FRAC_BITS:0] yc;
    logic [IN_FRAC_BITS:0] tc;
    skui_word_t dx_reg;
    skui_word_t dy_reg;
    skui_word_t dt_reg;

    // Lanes and combine.
    skui_point_ctrl_t point_ctrl;
    skui_diff_ctrl_t  diff_ctrl;
    skui_word_t kx;
    skui_word_t ky;
    skui_word_t kt;
    skui_word_t kx_dly_reg [ALIGN_LAT];
    skui_word_t ky_dly_reg [ALIGN_LAT];
    skui_word_t kt_dly_reg [SMUL_LAT];
    skui_word_t prod;
    skui_word_t v_next;
    skui_word_t v_reg;

    // Output rounding.
    logic [63:0]      vm_next;
    logic [64:0]      rnd_next;
    logic [MAG_W - 1:0] m_reg;
    logic             neg_reg;
    logic [63:0]      mx;
    logic [63:0]      lim;
    logic [63:0]      ms;
    skui_result_t     res_next;

    // Output buffer.
    skui_result_t buf_reg [FIFO_DEPTH];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;

    // APB register: writes land in the access phase, reads are immediate.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_KIND);
    assign prdata    = (paddr[2] == REG_KIND) ? DATA_W'(kind_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_RESET;
        end
        else if (cfg_write)
        begin
            kind_reg <= pwdata[2:0];
        end
    end

    // The whole pipeline moves together whenever the output buffer can take
    // the word that leaves its last stage.
    assign pop          = result_valid && !result_stall;
    assign pipe_en      = (cnt_reg != FIFO_FULL) || pop;
    assign push         = pipe_en && vld_reg[PIPE_LAT - 1];
    assign pair_stall   = !pipe_en;
    assign result_valid = (cnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            vld_reg[0] <= pair_valid;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i - 1];
            end
        end
    end

    // Points above one are clamped to one, then centred: d = t - 1/2.
    always_comb
    begin
        xc = (x_point > PT_ONE) ? PT_ONE : x_point;
        yc = (y_point > PT_ONE) ? PT_ONE : y_point;
        tc = (xc > yc) ? (xc - yc) : (yc - xc);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            last_reg[0] <= last_pair;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                last_reg[i] <= last_reg[i - 1];
            end
            dx_reg <= $signed(64'(xc) << CSH) - Q_HALF;
            dy_reg <= $signed(64'(yc) << CSH) - Q_HALF;
            dt_reg <= $signed(64'(tc) << CSH) - Q_HALF;
        end
    end

    // Kind decoder: the point lanes give k1..k4, the difference lane k2..k8.
    always_comb
    begin
        point_ctrl.asel   = ASEL_ONE;
        point_ctrl.b_is_d = 1'b1;
        point_ctrl.b_add  = '0;
        point_ctrl.p_add  = '0;
        point_ctrl.div    = DIV_1;
        diff_ctrl.c0      = -Q_1_2;
        diff_ctrl.use_u   = 3'b001;
        diff_ctrl.c1      = Q_7_240;
        diff_ctrl.c2      = '0;
        diff_ctrl.c3      = '0;
        diff_ctrl.div     = DIV_24;
        unique case (kind_reg)
            KIND_LINEAR:
            begin
                diff_ctrl.c0    = -Q_1_12;
                diff_ctrl.use_u = 3'b000;
                diff_ctrl.c1    = '0;
                diff_ctrl.div   = DIV_2;
            end
            KIND_CUBIC:
            begin
                point_ctrl.b_is_d = 1'b0;
                point_ctrl.b_add  = -Q_1_12;
                point_ctrl.div    = DIV_2;
            end
            KIND_QUINTIC:
            begin
                point_ctrl.asel   = ASEL_D;
                point_ctrl.b_is_d = 1'b0;
                point_ctrl.b_add  = -Q_1_4;
                point_ctrl.div    = DIV_6;
                diff_ctrl.c0      = -Q_5_4;
                diff_ctrl.use_u   = 3'b011;
                diff_ctrl.c1      = Q_7_16;
                diff_ctrl.c2      = -Q_31_1344;
                diff_ctrl.div     = DIV_720;
            end
            KIND_SEPTIC:
            begin
                point_ctrl.asel   = ASEL_U;
                point_ctrl.b_is_d = 1'b0;
                point_ctrl.b_add  = -Q_1_2;
                point_ctrl.p_add  = Q_7_240;
                point_ctrl.div    = DIV_24;
                diff_ctrl.c0      = -Q_7_3;
                diff_ctrl.use_u   = 3'b111;
                diff_ctrl.c1      = Q_49_24;
                diff_ctrl.c2      = -Q_31_48;
                diff_ctrl.c3      = Q_127_3840;
                diff_ctrl.div     = DIV_40320;
            end
            default:
            begin
            end
        endcase
    end

    skui_point_lane u_lane_x (
        .clk  (clk),
        .en   (pipe_en),
        .d    (dx_reg),
        .ctrl (point_ctrl),
        .k    (kx)
    );

    skui_point_lane u_lane_y (
        .clk  (clk),
        .en   (pipe_en),
        .d    (dy_reg),
        .ctrl (point_ctrl),
        .k    (ky)
    );

    skui_diff_lane u_lane_t (
        .clk  (clk),
        .en   (pipe_en),
        .d    (dt_reg),
        .ctrl (diff_ctrl),
        .k    (kt)
    );

    // The point lanes finish early and wait for the difference lane; the
    // difference term then waits for the product of the point terms.
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            kx_dly_reg[0] <= kx;
            ky_dly_reg[0] <= ky;
            for (int i = 1; i < ALIGN_LAT; i++)
            begin
                kx_dly_reg[i] <= kx_dly_reg[i - 1];
                ky_dly_reg[i] <= ky_dly_reg[i - 1];
            end
            kt_dly_reg[0] <= kt;
            for (int i = 1; i < SMUL_LAT; i++)
            begin
                kt_dly_reg[i] <= kt_dly_reg[i - 1];
            end
        end
    end

    skui_smul u_prod (
        .clk   (clk),
        .en    (pipe_en),
        .a     (kx_dly_reg[ALIGN_LAT - 1]),
        .a_add ('0),
        .b     (ky_dly_reg[ALIGN_LAT - 1]),
        .p     (prod)
    );

    always_comb
    begin
        case (kind_reg) inside
            KIND_LINEAR, KIND_QUINTIC: v_next = prod + kt_dly_reg[SMUL_LAT - 1];
            KIND_CUBIC, KIND_SEPTIC:   v_next = prod - kt_dly_reg[SMUL_LAT - 1];
            KIND_PERIODIC:             v_next = -kt_dly_reg[SMUL_LAT - 1];
            default:                   v_next = '0;
        endcase
        vm_next  = v_reg[63] ? (64'd0 - $unsigned(v_reg)) : $unsigned(v_reg);
        rnd_next = {1'b0, vm_next} + RND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            v_reg   <= v_next;
            m_reg   <= rnd_next[64:SH];
            neg_reg <= v_reg[63];
        end
    end

    // Saturate the rounded magnitude and restore the sign.
    always_comb
    begin
        mx             = 64'(m_reg);
        lim            = neg_reg ? LIM_NEG : LIM_POS;
        ms             = (mx > lim) ? lim : mx;
        res_next.value = neg_reg ? $signed(KERNEL_W'(0) - ms[KERNEL_W - 1:0])
                                 : $signed(ms[KERNEL_W - 1:0]);
        res_next.last  = last_reg[PIPE_LAT - 1];
    end

    // Two word output buffer.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= res_next;
        end
    end

    assign kernel_value = buf_reg[rd_ptr_reg].value;
    assign last_out     = buf_reg[rd_ptr_reg].last;

    `SKUI_CHECK(a_buf_bound, cnt_reg <= FIFO_FULL, "output buffer count out of range")
    `SKUI_CHECK_NOW(a_push_room, push, cnt_reg != FIFO_FULL || pop,
        "word pushed into a full output buffer")
    `SKUI_CHECK_NEXT(a_accept_enters, pair_valid && !pair_stall, vld_reg[0],
        "accepted pair did not enter the pipeline")
    `SKUI_CHECK_NEXT(a_hold_tail, !pipe_en && vld_reg[PIPE_LAT - 1], vld_reg[PIPE_LAT - 1],
        "held pipeline dropped its last word")

endmodule

// File: bench/spline_kernel_checker.sv
// Checker for the unit interval spline kernel: follows register writes, predicts
// each kernel value and compares results in order. Depends on skui_pkg.
`timescale 1ns / 100ps

module spline_kernel_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pair_valid,
    input  logic                 pair_stall,
    input  logic [16:0]          x_point,
    input  logic [16:0]          y_point,
    input  logic                 last_pair,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  logic signed [47:0]   kernel_value,
    input  logic                 last_out,
    output int                   fail_count,
    output int                   pending,
    output int                   result_count
);
    import skui_pkg::*;

    typedef logic signed [63:0] fx_t;

    typedef struct packed {
        logic signed [47:0] value;
        logic               last;
    } kernel_word_t;

    localparam int FRAC = 60;
    localparam logic [2:0] KIND_ADDR = 3'(REG_KIND) * 3'd4;

    logic [2:0]   kind;
    kernel_word_t expected_words[$];

    function automatic fx_t fx_mag(fx_t a);
        return a < 0 ? -a : a;
    endfunction

    function automatic fx_t fx_mul(fx_t a, fx_t b);
        logic [127:0] p;
        logic [63:0]  r;
        p = {64'd0, fx_mag(a)} * {64'd0, fx_mag(b)};
        r = p[123:60] + p[59];
        return ((a < 0) != (b < 0)) ? -fx_t'(r) : fx_t'(r);
    endfunction

    function automatic fx_t fx_div(fx_t a, int unsigned den);
        logic [63:0] q;
        q = (fx_mag(a) + den / 2) / den;
        return a < 0 ? -fx_t'(q) : fx_t'(q);
    endfunction

    // p/q with 60 fraction bits, rounded to nearest, ties up.
    function automatic fx_t fx_ratio(int unsigned num, int unsigned den);
        logic [127:0] t;
        t = ({96'd0, num} << (FRAC + 1)) / den;
        return fx_t'((t + 128'd1) >> 1);
    endfunction

    function automatic fx_t centered(logic [16:0] t);
        return fx_t'({47'd0, t} << (FRAC - 16)) - (fx_t'(1) <<< (FRAC - 1));
    endfunction

    function automatic fx_t bern2(fx_t d);
        return fx_div(fx_mul(d, d) - fx_ratio(1, 12), 2);
    endfunction

    function automatic fx_t bern3(fx_t d);
        return fx_div(fx_mul(d, fx_mul(d, d) - fx_ratio(1, 4)), 6);
    endfunction

    function automatic fx_t bern4(fx_t d);
        fx_t u;
        u = fx_mul(d, d);
        return fx_div(fx_mul(u - fx_ratio(1, 2), u) + fx_ratio(7, 240), 24);
    endfunction

    function automatic fx_t bern6(fx_t d);
        fx_t u, p;
        u = fx_mul(d, d);
        p = fx_mul(u - fx_ratio(5, 4), u) + fx_ratio(7, 16);
        p = fx_mul(p, u) - fx_ratio(31, 1344);
        return fx_div(p, 720);
    endfunction

    function automatic fx_t bern8(fx_t d);
        fx_t u, p;
        u = fx_mul(d, d);
        p = fx_mul(u - fx_ratio(7, 3), u) + fx_ratio(49, 24);
        p = fx_mul(p, u) - fx_ratio(31, 48);
        p = fx_mul(p, u) + fx_ratio(127, 3840);
        return fx_div(p, 40320);
    endfunction

    // Rounds from 60 to 44 fraction bits and saturates to 48 bits.
    function automatic logic signed [47:0] to_q3_44(fx_t v);
        logic [63:0] m, lim;
        m = (fx_mag(v) + 64'd32768) >> 16;
        lim = v < 0 ? 64'd1 << 47 : (64'd1 << 47) - 1;
        if (m > lim)
            m = lim;
        return v < 0 ? -(48'(m)) : 48'(m);
    endfunction

    function automatic logic signed [47:0] kernel_of(logic [2:0] k, logic [16:0] x,
                                                     logic [16:0] y);
        logic [16:0] cx, cy, t;
        fx_t dx, dy, dt, v;
        cx = x > 17'd65536 ? 17'd65536 : x;
        cy = y > 17'd65536 ? 17'd65536 : y;
        t = cx > cy ? cx - cy : cy - cx;
        dx = centered(cx);
        dy = centered(cy);
        dt = centered(t);
        case (k)
            KIND_LINEAR:   v = fx_mul(dx, dy) + bern2(dt);
            KIND_CUBIC:    v = fx_mul(bern2(dx), bern2(dy)) - bern4(dt);
            KIND_QUINTIC:  v = fx_mul(bern3(dx), bern3(dy)) + bern6(dt);
            KIND_SEPTIC:   v = fx_mul(bern4(dx), bern4(dy)) - bern8(dt);
            KIND_PERIODIC: v = -bern4(dt);
            default:       v = 0;
        endcase
        return to_q3_44(v);
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: MISMATCH %s", $time, what);
        fail_count++;
    endtask

    assign pending = expected_words.size();

    always @(posedge clk or negedge rst_n) begin
        kernel_word_t got, want;
        if (!rst_n) begin
            kind = KIND_RESET;
            expected_words.delete();
            fail_count = 0;
            result_count = 0;
        end
        else begin
            // Results are compared before the new pair is queued; latency keeps them apart.
            if (result_valid && !result_stall) begin
                got = '{kernel_value, last_out};
                result_count++;
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", got));
                else begin
                    want = expected_words.pop_front();
                    if (got.value !== want.value)
                        report_mismatch($sformatf("kernel_value %h, want %h",
                                                  got.value, want.value));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last_out %b, want %b",
                                                  got.last, want.last));
                end
            end
            if (pair_valid && !pair_stall)
                expected_words.push_back('{kernel_of(kind, x_point, y_point), last_pair});
            if (psel && penable && pwrite && pready && paddr == KIND_ADDR)
                kind = pwdata[2:0];
        end
    end

endmodule

// File: bench/tb_spline_kernel_unit_interval.sv
// Top of the spline kernel testbench: clock, reset, register writes, pair stimulus
// and the verdict. Depends on skui_pkg, the block and spline_kernel_checker.
`timescale 1ns / 100ps

module tb_spline_kernel_unit_interval;
    import skui_pkg::*;

    // Idle modes of a phase: none, sender only, receiver only, both lightly.
    localparam int MODE_NONE = 0;
    localparam int MODE_SEND = 1;
    localparam int MODE_RECV = 2;
    localparam int MODE_BOTH = 3;
    localparam int PHASES = 16;
    localparam int WORDS_PER_PHASE = 97;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [2:0] KIND_ADDR = 3'(REG_KIND) * 3'd4;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pair_valid, pair_stall, last_pair;
    logic [16:0] x_point, y_point;
    logic result_valid, result_stall, last_out;
    logic signed [47:0] kernel_value;

    int fail_count, pending, result_count;
    int idle_mode;

    spline_kernel_unit_interval dut (.*);

    spline_kernel_checker checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The receiver stalls at random according to the current idle mode.
    always @(posedge clk) begin
        case (idle_mode)
            MODE_RECV: result_stall <= ($urandom_range(99) < 79);
            MODE_BOTH: result_stall <= ($urandom_range(99) < 6);
            default:   result_stall <= 1'b0;
        endcase
    end

    // A hard limit far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    // Setup cycle, then the access cycle at whose end the register takes the value.
    task automatic write_kind(logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= KIND_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offers one pair word, with sender gaps before it, and returns once it is taken.
    task automatic send_pair(logic [16:0] x, logic [16:0] y, logic last);
        int gap_pct;
        gap_pct = idle_mode == MODE_SEND ? 79 : idle_mode == MODE_BOTH ? 6 : 0;
        while ($urandom_range(99) < gap_pct) begin
            pair_valid <= 1'b0;
            @(posedge clk);
        end
        pair_valid <= 1'b1;
        x_point <= x;
        y_point <= y;
        last_pair <= last;
        @(posedge clk);
        while (pair_stall)
            @(posedge clk);
    endtask

    // Holds the sender until every result is in, then lets the pipeline settle.
    task automatic drain();
        pair_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [16:0] random_point();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return 17'd0;
        else if (pick < 10)
            return 17'd65536;
        else if (pick < 20)
            return 17'($urandom);           // may exceed one and get clamped
        return 17'($urandom_range(65536));
    endfunction

    initial begin
        logic [16:0] corner[8];
        int kind_sel;
        corner = '{17'd0, 17'd65536, 17'd32768, 17'd1, 17'd65535,
                   17'd131071, 17'd65537, 17'd16384};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pair_valid = 1'b0;
        x_point = '0;
        y_point = '0;
        last_pair = 1'b0;
        result_stall = 1'b0;
        idle_mode = MODE_NONE;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset kind: endpoints, the midpoint, points above one,
        // and both values of the last flag.
        for (int i = 0; i < 8; i++)
            send_pair(corner[i], corner[(i * 3 + 1) % 8], i[0]);
        // Two extreme pairs for every kind, unused codes included.
        for (int k = 0; k < 8; k++) begin
            drain();
            write_kind(32'(k));
            send_pair(17'd0, 17'd65536, 1'b1);
            send_pair(17'd131071, 17'd0, 1'b0);
        end

        // Random phases: every kind code runs twice and all four idle modes appear.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            idle_mode = (p / 2) % 4;
            kind_sel = p % 8;
            // Upper bits of the write are junk; only the low three bits count.
            write_kind({$urandom} & 32'hFFFF_FFF8 | 32'(kind_sel));
            for (int i = 0; i < WORDS_PER_PHASE; i++)
                send_pair(random_point(), random_point(), 1'($urandom_range(1)));
        end

        drain();
        idle_mode = MODE_NONE;
        $display("Checked %0d kernel words over all eight kind codes and four idle modes.",
                 result_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
